[hdl/utf8rms_pkg.sv]
// Package of types, constants and byte classification helpers for the UTF-8 repair unit.
package utf8rms_pkg;

	localparam logic [7:0] REP_BYTE0 = 8'hEF;
	localparam logic [7:0] REP_BYTE1 = 8'hBF;
	localparam logic [7:0] REP_BYTE2 = 8'hBD;

	localparam logic [7:0] LEAD2_MIN  = 8'hC2;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD4_MIN  = 8'hF0;
	localparam logic [7:0] LEAD_LIMIT = 8'hF5;
	localparam logic [7:0] LEAD_E0    = 8'hE0;
	localparam logic [7:0] LEAD_ED    = 8'hED;
	localparam logic [7:0] LEAD_F0    = 8'hF0;
	localparam logic [7:0] LEAD_F4    = 8'hF4;
	localparam logic [7:0] CONT_MIN   = 8'h80;
	localparam logic [7:0] CONT_MAX   = 8'hBF;
	localparam logic [7:0] E0_LO      = 8'hA0;
	localparam logic [7:0] ED_HI      = 8'h9F;
	localparam logic [7:0] F0_LO      = 8'h90;
	localparam logic [7:0] F4_HI      = 8'h8F;
	localparam logic [7:0] CONT_MASK  = 8'hC0;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [2:0] cnt;
		logic       repl;
		logic       last;
	} res_t;

	localparam res_t REP_RES = '{b0: REP_BYTE0, b1: REP_BYTE1, b2: REP_BYTE2, b3: 8'h00,
		cnt: 3'd3, repl: 1'b1, last: 1'b0};

	// Length promised by a start byte; zero for a byte that cannot begin a scalar.
	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		priority if (b < CONT_MIN) len = 3'd1;
		else if (b < LEAD2_MIN) len = 3'd0;
		else if (b < LEAD3_MIN) len = 3'd2;
		else if (b < LEAD4_MIN) len = 3'd3;
		else if (b < LEAD_LIMIT) len = 3'd4;
		else len = 3'd0;
		return len;
	endfunction

	// Second byte range depends on the lead, excluding overlongs, surrogates and
	// values above the top of the code space.
	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = CONT_MIN;
		hi = CONT_MAX;
		unique case (lead)
			LEAD_E0: lo = E0_LO;
			LEAD_ED: hi = ED_HI;
			LEAD_F0: lo = F0_LO;
			LEAD_F4: hi = F4_HI;
			default: lo = CONT_MIN;
		endcase
		return (b >= lo) && (b <= hi);
	endfunction

endpackage

[hdl/utf8_repair_maximal_subpart_unit.sv]
// Top level of the UTF-8 repair unit with maximal-subpart replacement.
// A result is written into the result queue when the byte that completes it is accepted.
// Throughput: one byte a cycle; each byte gives zero, one or two results, and results leave one
// a cycle when out_stall is low, via a four-entry queue stalling input below two free slots.
// Reset: arst_n clears the held prefix and empties the queue; held bytes are not cleared.
module utf8_repair_maximal_subpart_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte0,
	output logic [7:0] out_byte1,
	output logic [7:0] out_byte2,
	output logic [7:0] out_byte3,
	output logic [2:0] byte_count,
	output logic       replaced,
	output logic       last_of_text
);
	import utf8rms_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);

	logic [7:0]     pend_q [3];
	logic [1:0]     held_q;
	logic [2:0]     exp_q;

	res_t           queue_q [QDEPTH];
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW:0]   count_q;

	logic [7:0]     pend_nx [3];
	logic [1:0]     held_nx;
	logic [2:0]     exp_nx;
	res_t           res0;
	res_t           res1;
	res_t           emit;
	logic [1:0]     nres;
	logic           start_now;
	logic           ok;
	logic [2:0]     len;
	logic           in_acc;
	logic           out_acc;
	logic [QPW-1:0] wr_ptr1;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign in_stall = count_q > (QPW+1)'(QDEPTH - 2);
	assign wr_ptr1  = wr_ptr_q + 1'b1;

	always_comb begin
		res0      = '0;
		res1      = '0;
		emit      = '0;
		nres      = 2'd0;
		start_now = 1'b0;
		pend_nx   = pend_q;
		held_nx   = held_q;
		exp_nx    = exp_q;
		len       = lead_length(data_byte);
		ok        = (held_q == 2'd1) ? second_ok(pend_q[0], data_byte)
			: ((data_byte & CONT_MASK) == CONT_MIN);

		if (held_q == 2'd0 || exp_q < 3'd2 || {1'b0, held_q} >= exp_q) begin
			held_nx   = 2'd0;
			exp_nx    = 3'd0;
			start_now = 1'b1;
		end else if (!ok) begin
			res0      = REP_RES;
			nres      = 2'd1;
			held_nx   = 2'd0;
			exp_nx    = 3'd0;
			start_now = 1'b1;
		end else if ({1'b0, held_q} + 3'd1 == exp_q) begin
			res0.b0  = pend_q[0];
			res0.cnt = exp_q;
			unique case (held_q)
				2'd1: res0.b1 = data_byte;
				2'd2: begin
					res0.b1 = pend_q[1];
					res0.b2 = data_byte;
				end
				2'd3: begin
					res0.b1 = pend_q[1];
					res0.b2 = pend_q[2];
					res0.b3 = data_byte;
				end
				default: res0.b0 = pend_q[0];
			endcase
			nres    = 2'd1;
			held_nx = 2'd0;
			exp_nx  = 3'd0;
		end else begin
			unique case (held_q)
				2'd1:    pend_nx[1] = data_byte;
				2'd2:    pend_nx[2] = data_byte;
				default: pend_nx[0] = pend_q[0];
			endcase
			held_nx = held_q + 2'd1;
		end

		// The offending or fresh byte is taken as a new start.
		if (start_now) begin
			if (len == 3'd0 || len == 3'd1) begin
				if (len == 3'd0) begin
					emit = REP_RES;
				end else begin
					emit.b0  = data_byte;
					emit.cnt = 3'd1;
				end
				if (nres == 2'd0) res0 = emit;
				else res1 = emit;
				nres = nres + 2'd1;
			end else begin
				pend_nx[0] = data_byte;
				held_nx    = 2'd1;
				exp_nx     = len;
			end
		end

		if (end_of_text) begin
			if (held_nx != 2'd0) begin
				if (nres == 2'd0) res0 = REP_RES;
				else res1 = REP_RES;
				nres = nres + 2'd1;
			end
			held_nx = 2'd0;
			exp_nx  = 3'd0;
			if (nres == 2'd2) res1.last = 1'b1;
			else if (nres == 2'd1) res0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
			exp_q  <= 3'd0;
		end else if (in_acc) begin
			held_q <= held_nx;
			exp_q  <= exp_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pend_q <= pend_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && nres != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
			if (nres == 2'd2) begin
				queue_q[wr_ptr1] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= wr_ptr_q + QPW'(nres);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (in_acc ? (QPW+1)'(nres) : '0)
				- (out_acc ? (QPW+1)'(1) : '0);
		end
	end

	assign out_valid    = count_q != '0;
	assign out_byte0    = queue_q[rd_ptr_q].b0;
	assign out_byte1    = queue_q[rd_ptr_q].b1;
	assign out_byte2    = queue_q[rd_ptr_q].b2;
	assign out_byte3    = queue_q[rd_ptr_q].b3;
	assign byte_count   = queue_q[rd_ptr_q].cnt;
	assign replaced     = queue_q[rd_ptr_q].repl;
	assign last_of_text = queue_q[rd_ptr_q].last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPW+1)'(QDEPTH))
		else $error("result queue holds more words than it has slots");

	a_held_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != 2'd0 |-> (exp_q >= 3'd2 && {1'b0, held_q} < exp_q))
		else $error("held prefix is not shorter than its promised length");

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && end_of_text |=> held_q == 2'd0)
		else $error("scalar still held after an end-of-text word");

	a_eot_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && end_of_text |-> nres != 2'd0)
		else $error("end-of-text word gave no result");

	a_rep_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && replaced |-> (byte_count == 3'd3 && out_byte0 == REP_BYTE0
			&& out_byte1 == REP_BYTE1 && out_byte2 == REP_BYTE2))
		else $error("replacement result is not the replacement character");

endmodule

[tb/sv/tb_utf8_repair_checker.sv]
`timescale 1ns / 100ps
// Checker for the UTF-8 repair unit: predicts the emitted scalars and compares them.
module tb_utf8_repair_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte0,
	input  logic [7:0] out_byte1,
	input  logic [7:0] out_byte2,
	input  logic [7:0] out_byte3,
	input  logic [2:0] byte_count,
	input  logic       replaced,
	input  logic       last_of_text,
	output int         mismatches,
	output int         awaited,
	output int         scalars_seen,
	output int         repairs_seen
);
	import utf8rms_pkg::*;

	logic [7:0] held_bytes [3];
	logic [2:0] scalar_len;
	logic [1:0] held_n;
	res_t       expected_scalars [$];
	res_t       step_out [2];
	int         step_n;
	res_t       got;
	res_t       want;

	function automatic logic [2:0] promised_len(input logic [7:0] b);
		if (b < CONT_MIN) return 3'd1;
		if (b < LEAD2_MIN) return 3'd0;
		if (b < LEAD3_MIN) return 3'd2;
		if (b < LEAD4_MIN) return 3'd3;
		if (b < LEAD_LIMIT) return 3'd4;
		return 3'd0;
	endfunction

	// The lead decides which second bytes are allowed, ruling out overlongs,
	// surrogates and anything past the top of the code space.
	function automatic logic second_in_range(input logic [7:0] lead, input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = CONT_MIN;
		hi = CONT_MAX;
		case (lead)
			LEAD_E0: lo = E0_LO;
			LEAD_ED: hi = ED_HI;
			LEAD_F0: lo = F0_LO;
			LEAD_F4: hi = F4_HI;
			default: ;
		endcase
		return (b >= lo) && (b <= hi);
	endfunction

	function automatic res_t whole_scalar(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] n);
		res_t r;
		r.b0 = b0;
		r.b1 = b1;
		r.b2 = b2;
		r.b3 = b3;
		r.cnt = n;
		r.repl = 1'b0;
		r.last = 1'b0;
		return r;
	endfunction

	task push_scalar(input res_t r);
		step_out[step_n] = r;
		step_n++;
	endtask

	task drop_held();
		held_n = 2'd0;
		scalar_len = 3'd0;
	endtask

	task begin_scalar(input logic [7:0] b);
		logic [2:0] n;
		n = promised_len(b);
		if (n == 3'd0) begin
			push_scalar(REP_RES);
		end else if (n == 3'd1) begin
			push_scalar(whole_scalar(b, 8'h00, 8'h00, 8'h00, 3'd1));
		end else begin
			held_bytes[0] = b;
			held_n = 2'd1;
			scalar_len = n;
		end
	endtask

	task predict_scalars(input logic [7:0] b, input logic eot);
		logic       fits;
		logic [7:0] v [4];
		int         i;
		step_n = 0;
		if (held_n == 2'd0 || scalar_len < 3'd2 || {1'b0, held_n} >= scalar_len) begin
			drop_held();
			begin_scalar(b);
		end else begin
			fits = (held_n == 2'd1) ? second_in_range(held_bytes[0], b)
				: ((b & CONT_MASK) == CONT_MIN);
			if (!fits) begin
				// The held prefix is replaced and the offending byte starts afresh.
				push_scalar(REP_RES);
				drop_held();
				begin_scalar(b);
			end else if ({1'b0, held_n} + 3'd1 == scalar_len) begin
				for (i = 0; i < 4; i++)
					v[i] = (i < held_n) ? held_bytes[i] : 8'h00;
				v[held_n] = b;
				push_scalar(whole_scalar(v[0], v[1], v[2], v[3], scalar_len));
				drop_held();
			end else begin
				held_bytes[held_n] = b;
				held_n = held_n + 2'd1;
			end
		end
		if (eot) begin
			if (held_n != 2'd0) begin
				push_scalar(REP_RES);
				drop_held();
			end
			if (step_n > 0)
				step_out[step_n - 1].last = 1'b1;
		end
		for (i = 0; i < step_n; i++)
			expected_scalars.insert(expected_scalars.size(), step_out[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes[0] = 8'h00;
			held_bytes[1] = 8'h00;
			held_bytes[2] = 8'h00;
			drop_held();
			expected_scalars.delete();
			mismatches = 0;
			awaited = 0;
			scalars_seen = 0;
			repairs_seen = 0;
		end else begin
			// A result never belongs to a byte taken at the same edge, so the
			// output side is checked before the new byte is predicted.
			if (out_valid && !out_stall) begin
				got = {out_byte0, out_byte1, out_byte2, out_byte3, byte_count, replaced,
					last_of_text};
				scalars_seen++;
				if (replaced)
					repairs_seen++;
				if (expected_scalars.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected scalar %h %h %h %h cnt %0d repl %b last %b",
						$time, got.b0, got.b1, got.b2, got.b3, got.cnt, got.repl, got.last);
				end else begin
					want = expected_scalars.pop_front();
					if (got !== want) begin
						mismatches++;
						$display("%0t: expected %h %h %h %h cnt %0d repl %b last %b,",
							$time, want.b0, want.b1, want.b2, want.b3, want.cnt, want.repl,
							want.last, " got %h %h %h %h cnt %0d repl %b last %b",
							got.b0, got.b1, got.b2, got.b3, got.cnt, got.repl, got.last);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_scalars(data_byte, end_of_text);
			awaited = expected_scalars.size();
		end
	end

endmodule

[tb/sv/tb_utf8_repair_maximal_subpart_unit.sv]
`timescale 1ns / 100ps
// Testbench top for the UTF-8 repair unit: clock, reset, byte stimulus, output pacing and verdict.
module tb_utf8_repair_maximal_subpart_unit;
	import utf8rms_pkg::*;

	localparam int BYTES_GOAL  = 1250;
	localparam int HOLD_CYCLES = 200;
	localparam int IDLE_LIMIT  = 3000;
	localparam int DRAIN_EVERY = 25;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       end_of_text;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte0;
	logic [7:0] out_byte1;
	logic [7:0] out_byte2;
	logic [7:0] out_byte3;
	logic [2:0] byte_count;
	logic       replaced;
	logic       last_of_text;

	int mismatches;
	int awaited;
	int scalars_seen;
	int repairs_seen;

	int bytes_sent = 0;
	int texts_sent = 0;
	int drains = 0;
	int hold_asks = 0;
	int hold_done = 0;
	int quiet_cycles = 0;

	logic [7:0] text_bytes [$];

	// Opening words, end of text in bit 8: edges of ASCII, shortest and longest
	// valid scalars, rejected leads, a stray continuation, bad second bytes after
	// each special lead, a bad third byte, a bad byte that is itself a new lead,
	// and an end of text both inside and after a scalar.
	logic [8:0] opening_words [26] = '{
		9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
		9'h0C0, 9'h0FF, 9'h080, 9'h0E0, 9'h080, 9'h0ED, 9'h0A0, 9'h0F4, 9'h090,
		9'h0E1, 9'h080, 9'h041, 9'h0F0, 9'h0C3, 9'h0A9, 9'h0E2, 9'h182, 9'h141};

	utf8_repair_maximal_subpart_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte0    (out_byte0),
		.out_byte1    (out_byte1),
		.out_byte2    (out_byte2),
		.out_byte3    (out_byte3),
		.byte_count   (byte_count),
		.replaced     (replaced),
		.last_of_text (last_of_text)
	);

	tb_utf8_repair_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte0    (out_byte0),
		.out_byte1    (out_byte1),
		.out_byte2    (out_byte2),
		.out_byte3    (out_byte3),
		.byte_count   (byte_count),
		.replaced     (replaced),
		.last_of_text (last_of_text),
		.mismatches   (mismatches),
		.awaited      (awaited),
		.scalars_seen (scalars_seen),
		.repairs_seen (repairs_seen)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Pace 0 never idles; pace 1 idles now and then; pace 2 idles often.
	function automatic int gap_for(input int pace);
		int r;
		r = $urandom_range(0, 99);
		if (pace == 0)
			return 0;
		if (r < ((pace == 1) ? 75 : 40))
			return 0;
		if (r < ((pace == 1) ? 97 : 90))
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] second_byte(input logic [7:0] lead, input logic good);
		case (lead)
			LEAD_E0: return good ? 8'($urandom_range(E0_LO, CONT_MAX))
				: 8'($urandom_range(CONT_MIN, E0_LO - 1));
			LEAD_ED: return good ? 8'($urandom_range(CONT_MIN, ED_HI))
				: 8'($urandom_range(ED_HI + 1, CONT_MAX));
			LEAD_F0: return good ? 8'($urandom_range(F0_LO, CONT_MAX))
				: 8'($urandom_range(CONT_MIN, F0_LO - 1));
			LEAD_F4: return good ? 8'($urandom_range(CONT_MIN, F4_HI))
				: 8'($urandom_range(F4_HI + 1, CONT_MAX));
			default: begin
				if (good)
					return 8'($urandom_range(CONT_MIN, CONT_MAX));
				return $urandom_range(0, 1) ? 8'($urandom_range(0, CONT_MIN - 1))
					: 8'($urandom_range(CONT_MAX + 1, 255));
			end
		endcase
	endfunction

	// Mostly well-formed scalars; the rest are cut short, corrupted, given a bad
	// second byte or preceded by a noise byte.
	task automatic append_scalar();
		logic [7:0] seq [4];
		int len;
		int keep;
		int pick;
		int k;
		len = $urandom_range(1, 4);
		keep = len;
		pick = $urandom_range(0, 99);
		for (k = 1; k < 4; k++)
			seq[k] = 8'($urandom_range(CONT_MIN, CONT_MAX));
		case (len)
			1: seq[0] = 8'($urandom_range(0, CONT_MIN - 1));
			2: seq[0] = 8'($urandom_range(LEAD2_MIN, LEAD3_MIN - 1));
			3: seq[0] = 8'($urandom_range(LEAD3_MIN, LEAD4_MIN - 1));
			default: seq[0] = 8'($urandom_range(LEAD4_MIN, LEAD_LIMIT - 1));
		endcase
		if (len > 2)
			seq[1] = second_byte(seq[0], 1'b1);
		if (pick < 8 && len > 1)
			keep = $urandom_range(1, len - 1);
		else if (pick < 15)
			seq[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
		else if (pick < 21 && len > 1)
			seq[1] = second_byte(seq[0], 1'b0);
		else if (pick < 25)
			text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 255)));
		for (k = 0; k < keep; k++)
			text_bytes.insert(text_bytes.size(), seq[k]);
	endtask

	// Called just after a rising edge; returns at the edge that takes the word.
	task automatic offer(input logic [7:0] b, input logic last, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		end_of_text = last;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_text(input int scalars, input int pace);
		int i;
		text_bytes.delete();
		repeat (scalars) append_scalar();
		for (i = 0; i < text_bytes.size(); i++)
			offer(text_bytes[i], i == text_bytes.size() - 1, gap_for(pace));
		texts_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (awaited != 0) @(negedge clk);
		@(posedge clk);
		drains++;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		end_of_text = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		foreach (opening_words[i])
			offer(opening_words[i][7:0], opening_words[i][8], gap_for(1));
		texts_sent = 2;
		while (bytes_sent < BYTES_GOAL) begin
			if (texts_sent % DRAIN_EVERY == 0)
				drain();
			if (texts_sent == 10) begin
				// The receiver holds off while a long text is pushed without gaps.
				hold_asks = hold_asks + 1;
				send_text(40, 0);
			end else begin
				send_text(($urandom_range(0, 19) == 0) ? $urandom_range(20, 50)
					: $urandom_range(1, 10), $urandom_range(0, 2));
			end
		end
		drain();
		repeat (10) @(negedge clk);
		$display("run covered %0d bytes in %0d texts, %0d drains and one long receiver hold",
			bytes_sent, texts_sent, drains);
		$display("%0d scalars came out, %0d of them replacements", scalars_seen, repairs_seen);
		if (mismatches == 0 && awaited == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Receiver: short and occasional long stalls, calm stretches, and the long
	// hold when the sender asks for it.
	initial begin
		int run;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_done) begin
				hold_done = hold_asks;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall = 1'b0;
			end else if ($urandom_range(0, 99) < 35) begin
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				out_stall = 1'b1;
				repeat (run) @(negedge clk);
				out_stall = 1'b0;
			end else if ($urandom_range(0, 99) < 3) begin
				repeat ($urandom_range(30, 120)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved on either side for %0d cycles", $time, IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule

[filelist.f]
hdl/utf8rms_pkg.sv
hdl/utf8_repair_maximal_subpart_unit.sv
tb/sv/tb_utf8_repair_checker.sv
tb/sv/tb_utf8_repair_maximal_subpart_unit.sv
